### rtl/ntcdl_pkg.sv
// Shared constants, types and the resistance table of the NTC temperature converter.
package ntcdl_pkg;

	localparam int MV_W          = 16;
	localparam int OHM_W         = 20;
	localparam int TEMP_W        = 16;
	localparam int RES_FRAC_BITS = 4;
	localparam int PROD_W        = OHM_W + MV_W;
	localparam int NUM_W         = PROD_W + RES_FRAC_BITS;
	localparam int RES_W         = 23;
	localparam int TABLE_ENTRIES = 146;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int SEARCH_STEPS  = $clog2(TABLE_ENTRIES - 1);
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = OHM_W;

	localparam int TEMP_FIRST_DDEGC = -400;
	localparam int TEMP_STEP_DDEGC  = 10;

	localparam logic [TEMP_W-1:0] TEMP_COLD_CODE = 16'h8000;
	localparam logic [TEMP_W-1:0] TEMP_HOT_CODE  = 16'h7FFF;

	localparam logic [MV_W-1:0]  SUPPLY_RESET  = 16'd3000;
	localparam logic [OHM_W-1:0] DIVIDER_RESET = 20'd10000;

	localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_MV    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_OHM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NTC_IS_UPPER = 2'd2;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_COLD = 2'd1,
		ST_HOT  = 2'd2
	} status_t;

	// Datasheet resistances in centi-ohm, falling from -40 degC to 105 degC in 1 degC steps.
	localparam logic [31:0] CENTI_OHM [TABLE_ENTRIES] = '{
		33427440, 31290440, 29303360, 27454800, 25734310, 24132290, 22639880, 21248970,
		19952060, 18742270, 17613250, 16559150, 15574560, 14654510, 13794410, 12990000,
		12237370, 11532900, 10873220, 10255250, 9676110, 9133150, 8623900, 8146090,
		7697600, 7276460, 6880860, 6509110, 6159640, 5830990, 5521810, 5230840,
		4956900, 4698910, 4455856, 4226785, 4010820, 3807141, 3614983, 3433632,
		3262423, 3100734, 2947985, 2803635, 2667176, 2538136, 2416073, 2300571,
		2191245, 2087731, 1989690, 1896804, 1808775, 1725325, 1646190, 1571126,
		1499901, 1432301, 1368122, 1307173, 1249275, 1194259, 1141969, 1092254,
		1044975, 1000000, 957205, 916474, 877697, 840770, 805596, 772082,
		740143, 709696, 680664, 652974, 626558, 601351, 577292, 554322,
		532388, 511437, 491420, 472292, 454008, 436527, 419811, 403821,
		388523, 373884, 359872, 346458, 333612, 321308, 309522, 298227,
		287402, 277026, 267076, 257534, 248382, 239600, 231174, 223085,
		215321, 207865, 200705, 193827, 187219, 180869, 174765, 168898,
		163256, 157831, 152613, 147592, 142762, 138112, 133637, 129329,
		125180, 121185, 117336, 113628, 110055, 106611, 103291, 100091,
		97005, 94029, 91159, 88389, 85717, 83138, 80649, 78246,
		75926, 73685, 71521, 69431, 67411, 65460, 63574, 61751,
		59988, 58284
	};

	typedef logic [RES_W-1:0] res_table_t [TABLE_ENTRIES];

	// Converts the table to fixed-point ohms, rounded to nearest, at elaboration.
	function automatic res_table_t build_res_table();
		res_table_t  t;
		logic [31:0] c;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			c    = CENTI_OHM[k];
			t[k] = RES_W'(((c << RES_FRAC_BITS) + 32'd50) / 32'd100);
		end
		return t;
	endfunction

	localparam res_table_t RES_TABLE = build_res_table();

endpackage

### rtl/ntcdl_mul.sv
// Bit-serial shift-and-add multiplier: fixed resistor times a divider voltage.
module ntcdl_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [ntcdl_pkg::OHM_W-1:0]  multiplicand,
	input  logic [ntcdl_pkg::MV_W-1:0]   multiplier,
	output logic                         done,
	output logic [ntcdl_pkg::PROD_W-1:0] product
);

	localparam int CNT_W = $clog2(ntcdl_pkg::MV_W);

	logic [ntcdl_pkg::PROD_W-1:0] acc_q;
	logic [ntcdl_pkg::OHM_W-1:0]  mcand_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         run_q;
	logic                         done_q;
	logic [ntcdl_pkg::OHM_W:0]    sum;

	// The multiplier sits in the low half and is shifted out while the product grows in.
	always_comb begin
		sum = {1'b0, acc_q[ntcdl_pkg::PROD_W-1:ntcdl_pkg::MV_W]};
		if (acc_q[0]) begin
			sum = sum + {1'b0, mcand_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ntcdl_pkg::MV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q   <= {{ntcdl_pkg::OHM_W{1'b0}}, multiplier};
			mcand_q <= multiplicand;
		end else if (run_q) begin
			acc_q <= {sum, acc_q[ntcdl_pkg::MV_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

### rtl/ntcdl_div.sv
// Restoring divider, one quotient bit per cycle, giving the NTC resistance.
module ntcdl_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [ntcdl_pkg::NUM_W-1:0] dividend,
	input  logic [ntcdl_pkg::MV_W-1:0]  divisor,
	output logic                        done,
	output logic [ntcdl_pkg::NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(ntcdl_pkg::NUM_W);

	logic [ntcdl_pkg::MV_W-1:0]  rem_q;
	logic [ntcdl_pkg::MV_W-1:0]  dvs_q;
	logic [ntcdl_pkg::NUM_W-1:0] quo_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        run_q;
	logic                        done_q;
	logic [ntcdl_pkg::MV_W:0]    trial;
	logic [ntcdl_pkg::MV_W:0]    diff;
	logic                        ge;

	always_comb begin
		trial = {rem_q, quo_q[ntcdl_pkg::NUM_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ntcdl_pkg::NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend bits leave at the top as quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[ntcdl_pkg::MV_W-1:0] : trial[ntcdl_pkg::MV_W-1:0];
			quo_q <= {quo_q[ntcdl_pkg::NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/ntcdl_lookup.sv
// Binary table search for the bracketing segment and serial linear interpolation.
module ntcdl_lookup (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [ntcdl_pkg::RES_W-1:0]  res,
	output logic                         done,
	output logic [ntcdl_pkg::TEMP_W-1:0] temperature
);

	localparam int CNT_W   = $clog2(ntcdl_pkg::SEARCH_STEPS);
	localparam int QBITS   = 4;
	localparam int F_W     = ntcdl_pkg::RES_W + QBITS;
	localparam int IDX_W   = ntcdl_pkg::IDX_W;
	localparam int TEMP_W  = ntcdl_pkg::TEMP_W;

	typedef enum logic [2:0] {
		L_IDLE,
		L_SEARCH,
		L_PREP,
		L_DIV,
		L_FIN
	} lstate_t;

	lstate_t                    state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       done_q;
	logic [IDX_W-1:0]           lo_q;
	logic [IDX_W-1:0]           hi_q;
	logic [ntcdl_pkg::RES_W-1:0] res_q;
	logic [F_W-1:0]             f_q;
	logic [F_W-1:0]             dsh_q;
	logic [QBITS-1:0]           q_q;
	logic [TEMP_W-1:0]          temp_q;

	logic [IDX_W:0]              mid_sum;
	logic [IDX_W-1:0]            mid;
	logic                        mid_ok;
	logic [ntcdl_pkg::RES_W-1:0] top_val;
	logic [ntcdl_pkg::RES_W-1:0] bot_val;
	logic [ntcdl_pkg::RES_W-1:0] x;
	logic [ntcdl_pkg::RES_W-1:0] d;
	logic                        ge;
	logic signed [TEMP_W-1:0]    tk;
	logic                        round_up;

	always_comb begin
		mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} + (IDX_W + 1)'(1);
		mid      = mid_sum[IDX_W:1];
		mid_ok   = ntcdl_pkg::RES_TABLE[mid] >= res_q;
		top_val  = ntcdl_pkg::RES_TABLE[lo_q];
		bot_val  = ntcdl_pkg::RES_TABLE[lo_q + IDX_W'(1)];
		x        = top_val - res_q;
		d        = top_val - bot_val;
		ge       = f_q >= dsh_q;
		tk       = TEMP_W'(ntcdl_pkg::TEMP_FIRST_DDEGC)
		         + TEMP_W'({lo_q, 3'b000}) + TEMP_W'({lo_q, 1'b0});
		// Below zero degrees the quotient is rounded toward zero, i.e. up.
		round_up = tk[TEMP_W-1] && (f_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				state_q <= L_SEARCH;
				cnt_q   <= '0;
			end else begin
				case (state_q)
					L_IDLE: begin
						state_q <= L_IDLE;
					end
					L_SEARCH: begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (cnt_q == CNT_W'(ntcdl_pkg::SEARCH_STEPS - 1)) begin
							state_q <= L_PREP;
						end
					end
					L_PREP: begin
						cnt_q   <= '0;
						state_q <= L_DIV;
					end
					L_DIV: begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (cnt_q == CNT_W'(QBITS - 1)) begin
							state_q <= L_FIN;
						end
					end
					L_FIN: begin
						done_q  <= 1'b1;
						state_q <= L_IDLE;
					end
					default: begin
						state_q <= L_IDLE;
					end
				endcase
			end
		end
	end

	// The segment index lies in [lo, hi]; the entry at lo is never below the resistance.
	always_ff @(posedge clk) begin
		if (load) begin
			lo_q  <= '0;
			hi_q  <= IDX_W'(ntcdl_pkg::TABLE_ENTRIES - 2);
			res_q <= res;
		end else begin
			case (state_q)
				L_SEARCH: begin
					if (mid_ok) begin
						lo_q <= mid;
					end else begin
						hi_q <= mid - IDX_W'(1);
					end
				end
				L_PREP: begin
					f_q   <= F_W'({x, 3'b000}) + F_W'({x, 1'b0});
					dsh_q <= F_W'({d, 3'b000});
					q_q   <= '0;
				end
				L_DIV: begin
					if (ge) begin
						f_q <= f_q - dsh_q;
					end
					dsh_q <= dsh_q >> 1;
					q_q   <= {q_q[QBITS-2:0], ge};
				end
				L_FIN: begin
					temp_q <= tk + TEMP_W'(q_q) + TEMP_W'(round_up);
				end
				default: begin
					lo_q <= lo_q;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign temperature = temp_q;

endmodule

### rtl/ntc_divider_lut_temperature.sv
// Top level: configuration registers, sequencer and result register of the NTC converter.
// An in-range word passes through the multiplier (16 steps), the divider (40 steps), the
// table search (8 steps) and the interpolation (4 steps); a resistance outside the table ends
// after the divider, and a word whose divider voltage alone marks the NTC open or shorted is answered from idle.
// A new word is taken at the edge that ends the done cycle, and not while a word is still in work.
// Asynchronous reset loads the register defaults and idles the sequencer; done is never held.
module ntc_divider_lut_temperature (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	output logic                             done,
	input  logic [ntcdl_pkg::MV_W-1:0]       adc_mv,
	output logic signed [ntcdl_pkg::TEMP_W-1:0] temp_tenths,
	output logic [1:0]                       range_status,
	input  logic                             cfg_we,
	input  logic [ntcdl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ntcdl_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int MV_W  = ntcdl_pkg::MV_W;
	localparam int RES_W = ntcdl_pkg::RES_W;
	localparam int NUM_W = ntcdl_pkg::NUM_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_LOOK
	} state_t;

	state_t                        state_q;
	logic [MV_W-1:0]               supply_q;
	logic [ntcdl_pkg::OHM_W-1:0]   divider_q;
	logic                          upper_q;
	logic [MV_W-1:0]               den_q;
	logic                          done_q;
	logic [ntcdl_pkg::TEMP_W-1:0]  temp_q;
	logic [1:0]                    status_q;

	logic                          accept;
	logic                          adc_ge;
	logic [MV_W-1:0]               diff;
	logic                          open_early;
	logic                          short_early;
	logic                          mul_load;
	logic                          mul_done;
	logic [ntcdl_pkg::PROD_W-1:0]  product;
	logic                          div_load;
	logic                          div_done;
	logic [NUM_W-1:0]              quotient;
	logic                          open_res;
	logic                          short_res;
	logic                          look_load;
	logic                          look_done;
	logic [ntcdl_pkg::TEMP_W-1:0]  look_temp;

	always_comb begin
		accept      = start && (state_q == S_IDLE);
		adc_ge      = adc_mv >= supply_q;
		diff        = supply_q - adc_mv;
		open_early  = upper_q ? (adc_mv == '0) : adc_ge;
		short_early = upper_q && (adc_mv != '0) && adc_ge;
		mul_load    = accept && !open_early && !short_early;
		div_load    = (state_q == S_MUL) && mul_done;
		open_res    = (quotient[NUM_W-1:RES_W] != '0)
		            || (quotient[RES_W-1:0] > ntcdl_pkg::RES_TABLE[0]);
		short_res   = quotient[RES_W-1:0]
		            < ntcdl_pkg::RES_TABLE[ntcdl_pkg::TABLE_ENTRIES-1];
		look_load   = (state_q == S_DIV) && div_done && !open_res && !short_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q  <= ntcdl_pkg::SUPPLY_RESET;
			divider_q <= ntcdl_pkg::DIVIDER_RESET;
			upper_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ntcdl_pkg::CFG_SUPPLY_MV:    supply_q  <= cfg_data[MV_W-1:0];
				ntcdl_pkg::CFG_DIVIDER_OHM:  divider_q <= cfg_data;
				ntcdl_pkg::CFG_NTC_IS_UPPER: upper_q   <= cfg_data[0];
				default: begin
					upper_q <= upper_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			temp_q   <= '0;
			status_q <= ntcdl_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (open_early) begin
							done_q   <= 1'b1;
							temp_q   <= ntcdl_pkg::TEMP_COLD_CODE;
							status_q <= ntcdl_pkg::ST_COLD;
						end else if (short_early) begin
							done_q   <= 1'b1;
							temp_q   <= ntcdl_pkg::TEMP_HOT_CODE;
							status_q <= ntcdl_pkg::ST_HOT;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (open_res) begin
							done_q   <= 1'b1;
							temp_q   <= ntcdl_pkg::TEMP_COLD_CODE;
							status_q <= ntcdl_pkg::ST_COLD;
							state_q  <= S_IDLE;
						end else if (short_res) begin
							done_q   <= 1'b1;
							temp_q   <= ntcdl_pkg::TEMP_HOT_CODE;
							status_q <= ntcdl_pkg::ST_HOT;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					if (look_done) begin
						done_q   <= 1'b1;
						temp_q   <= look_temp;
						status_q <= ntcdl_pkg::ST_OK;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The divisor is the part of the divider that does not contain the NTC.
	always_ff @(posedge clk) begin
		if (mul_load) begin
			den_q <= upper_q ? adc_mv : diff;
		end
	end

	ntcdl_mul u_mul (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (mul_load),
		.multiplicand (divider_q),
		.multiplier   (upper_q ? diff : adc_mv),
		.done         (mul_done),
		.product      (product)
	);

	ntcdl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend ({product, {ntcdl_pkg::RES_FRAC_BITS{1'b0}}}),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (quotient)
	);

	ntcdl_lookup u_lookup (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (look_load),
		.res         (quotient[RES_W-1:0]),
		.done        (look_done),
		.temperature (look_temp)
	);

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign temp_tenths  = temp_q;
	assign range_status = status_q;

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result strobe without a word in work");

	a_busy_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobed while a word is still in work");

	a_cold_code: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (range_status == ntcdl_pkg::ST_COLD))
		|-> (temp_tenths == ntcdl_pkg::TEMP_COLD_CODE))
		else $error("cold status without the cold temperature code");

	a_status_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((range_status == ntcdl_pkg::ST_OK)
			|| (range_status == ntcdl_pkg::ST_COLD)
			|| (range_status == ntcdl_pkg::ST_HOT)))
		else $error("undefined range status");

endmodule
